@@ rtl/bfha_pkg.sv @@
// shared types and constants for the best-fit hole allocator
package bfha_pkg;

    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W = 7;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        CFG_BASE   = 1'b0,
        CFG_LENGTH = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_DECIDE,
        S_WR_A,
        S_WR_B,
        S_RESP
    } state_t;

endpackage

@@ rtl/bfha_if.sv @@
// valid/ready channel interfaces for requests and responses
interface bfha_req_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [ADDR_BITS-1:0] request_size;
    logic [4:0]           align_log2;
    logic [ADDR_BITS-1:0] free_start;

    modport source (output valid, op, request_size, align_log2, free_start, input ready);
    modport sink (input valid, op, request_size, align_log2, free_start, output ready);
endinterface

interface bfha_rsp_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] chunk_start;
    logic [6:0]           holes_in_use;

    modport source (output valid, status, chunk_start, holes_in_use, input ready);
    modport sink (input valid, status, chunk_start, holes_in_use, output ready);
endinterface

@@ rtl/bfha_ram.sv @@
// generic single-port ram with registered read
module bfha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/best_fit_hole_allocator.sv @@
// best-fit hole allocator top level
// allocate: one scan of the hole table, one entry a cycle through a single-port ram, then
// a decision and any table write before the response, a second write when a tail hole is made
// free: two scans, then the same decision and write, a second one when both neighbours merge
// the block returns to idle after each response transfer; a stalled response holds the block
// reset or any region write runs a clearing pass to one region hole (zero-length at 0 after reset)
module best_fit_hole_allocator #(
    parameter int MAX_HOLES = 64,
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    bfha_req_if.sink    req,
    bfha_rsp_if.source  rsp
);
    import bfha_pkg::*;

    localparam int IW = $clog2(MAX_HOLES);
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int A = ADDR_BITS;

    state_t state_reg, state_next;
    logic [A-1:0] rbase_reg, rlen_reg;
    logic [MAX_HOLES-1:0] valid_reg;
    logic [CW-1:0] used_reg;
    logic [IW:0] idx_reg;
    logic op_reg;
    logic [A-1:0] size_reg, fst_reg, amask_reg;
    logic [A-1:0] b_base_reg, b_len_reg, b_pad_reg;
    logic [IW-1:0] b_idx_reg, n_idx_reg;
    logic b_ok_reg, n_ok_reg;
    logic [1:0] st_reg;
    logic [A-1:0] chunk_reg;
    logic [A-1:0] n_len_reg;
    logic wb_two_reg;
    logic [IW-1:0] w2_idx_reg;
    logic [A-1:0] w2_base_reg, w2_len_reg;

    logic ram_we;
    logic [IW-1:0] ram_addr;
    logic [A-1:0] wb_base, wb_len, rd_base, rd_len;
    logic [IW-1:0] rd_idx_reg;
    logic rd_vld_reg;

    bfha_ram #(.WIDTH(A), .DEPTH(MAX_HOLES)) u_base (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wb_base), .rdata(rd_base));
    bfha_ram #(.WIDTH(A), .DEPTH(MAX_HOLES)) u_len (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wb_len), .rdata(rd_len));

    function automatic logic ram_issue_more(input logic [IW:0] i, input int n);
        ram_issue_more = (i < (IW+1)'(n));
    endfunction

    // lowest free slot
    logic [IW-1:0] free_idx;
    logic free_ok;
    always_comb
    begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = MAX_HOLES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    logic scan_active, last_issue;
    assign last_issue  = (idx_reg == (IW+1)'(MAX_HOLES - 1));
    assign scan_active = (state_reg == S_SCAN) || (state_reg == S_SCAN2);

    logic [A-1:0] pad, fend, hend;
    logic fits, better, entry_v;
    assign entry_v = valid_reg[rd_idx_reg] && rd_vld_reg;
    assign pad     = (A'(0) - rd_base) & amask_reg;
    assign fits    = (pad < rd_len) && ((rd_len - pad) >= size_reg);
    assign better  = !b_ok_reg || (rd_len < b_len_reg)
                     || ((rd_len == b_len_reg) && (rd_base < b_base_reg));
    assign hend    = rd_base + rd_len;
    assign fend    = fst_reg + size_reg;

    // decision arithmetic
    logic [A-1:0] left;
    assign left = b_len_reg - b_pad_reg - size_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:   if (last_issue) state_next = S_IDLE;
            S_IDLE:   if (req.valid) state_next = S_SCAN;
            S_SCAN:   if (rd_vld_reg && !ram_issue_more(idx_reg, MAX_HOLES))
                          state_next = (op_reg == OP_FREE) ? S_SCAN2 : S_DECIDE;
            S_SCAN2:  if (rd_vld_reg && !ram_issue_more(idx_reg, MAX_HOLES))
                          state_next = S_DECIDE;
            S_DECIDE: state_next = S_WR_A;
            S_WR_A:   state_next = wb_two_reg ? S_WR_B : S_RESP;
            S_WR_B:   state_next = S_RESP;
            S_RESP:   if (rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        if (cfg_we) state_next = S_INIT;
    end

    // write port selection
    logic [IW-1:0] wa_idx;
    logic [A-1:0] wa_base, wa_len;
    logic wa_en;
    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = idx_reg[IW-1:0];
        wb_base  = '0;
        wb_len   = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we  = 1'b1;
                wb_base = (idx_reg == '0) ? rbase_reg : '0;
                wb_len  = (idx_reg == '0) ? rlen_reg : '0;
            end
            S_WR_A:
            begin
                ram_we   = wa_en;
                ram_addr = wa_idx;
                wb_base  = wa_base;
                wb_len   = wa_len;
            end
            S_WR_B:
            begin
                ram_we   = 1'b1;
                ram_addr = w2_idx_reg;
                wb_base  = w2_base_reg;
                wb_len   = w2_len_reg;
            end
            default: ;
        endcase
    end

    logic [IW-1:0] wa_idx_reg;
    logic [A-1:0] wa_base_reg, wa_len_reg;
    logic wa_en_reg;
    assign wa_idx  = wa_idx_reg;
    assign wa_base = wa_base_reg;
    assign wa_len  = wa_len_reg;
    assign wa_en   = wa_en_reg;

    assign req.ready        = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid        = (state_reg == S_RESP);
    assign rsp.status       = st_reg;
    assign rsp.chunk_start  = chunk_reg;
    assign rsp.holes_in_use = 7'(used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            rbase_reg <= '0;
            rlen_reg  <= '0;
            valid_reg <= MAX_HOLES'(1);
            used_reg  <= CW'(1);
            idx_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= scan_active && ram_issue_more(idx_reg, MAX_HOLES);
            rd_idx_reg <= idx_reg[IW-1:0];
            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE) rbase_reg <= A'(cfg_wdata);
                else rlen_reg <= A'(cfg_wdata);
                valid_reg <= MAX_HOLES'(1);
                used_reg  <= CW'(1);
                idx_reg   <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_INIT:
                        idx_reg <= idx_reg + 1'b1;
                    S_IDLE:
                    begin
                        idx_reg <= '0;
                        if (req.valid)
                        begin
                            op_reg    <= req.op;
                            size_reg  <= req.request_size;
                            fst_reg   <= req.free_start;
                            amask_reg <= (A'(1) << req.align_log2) - A'(1);
                            b_ok_reg  <= 1'b0;
                            n_ok_reg  <= 1'b0;
                        end
                    end
                    S_SCAN:
                    begin
                        if (ram_issue_more(idx_reg, MAX_HOLES)) idx_reg <= idx_reg + 1'b1;
                        else if (rd_vld_reg && op_reg == OP_FREE) idx_reg <= '0;
                        if (entry_v)
                        begin
                            if (op_reg == OP_ALLOC)
                            begin
                                if (fits && better)
                                begin
                                    b_ok_reg   <= 1'b1;
                                    b_idx_reg  <= rd_idx_reg;
                                    b_base_reg <= rd_base;
                                    b_len_reg  <= rd_len;
                                    b_pad_reg  <= pad;
                                end
                            end
                            else if (!b_ok_reg && hend == fst_reg)
                            begin
                                b_ok_reg   <= 1'b1;
                                b_idx_reg  <= rd_idx_reg;
                                b_base_reg <= rd_base;
                                b_len_reg  <= rd_len;
                            end
                        end
                    end
                    S_SCAN2:
                    begin
                        if (ram_issue_more(idx_reg, MAX_HOLES)) idx_reg <= idx_reg + 1'b1;
                        if (entry_v && !n_ok_reg && rd_base == fend
                            && !(b_ok_reg && b_idx_reg == rd_idx_reg))
                        begin
                            n_ok_reg  <= 1'b1;
                            n_idx_reg <= rd_idx_reg;
                            n_len_reg <= rd_len;
                        end
                    end
                    S_DECIDE:
                    begin
                        st_reg     <= ST_OK;
                        chunk_reg  <= '0;
                        wa_en_reg  <= 1'b0;
                        wb_two_reg <= 1'b0;
                        wa_idx_reg <= b_idx_reg;
                        wa_base_reg <= b_base_reg;
                        wa_len_reg <= b_len_reg;
                        if (op_reg == OP_ALLOC)
                        begin
                            if (size_reg == '0 || !b_ok_reg)
                                st_reg <= ST_NOFIT;
                            else if (size_reg == b_len_reg)
                            begin
                                chunk_reg <= b_base_reg;
                                wa_en_reg <= 1'b1;
                                wa_base_reg <= '0;
                                wa_len_reg <= '0;
                                valid_reg[b_idx_reg] <= 1'b0;
                                used_reg <= used_reg - 1'b1;
                            end
                            else if (b_pad_reg == '0)
                            begin
                                chunk_reg <= b_base_reg;
                                wa_en_reg <= 1'b1;
                                wa_base_reg <= b_base_reg + size_reg;
                                wa_len_reg <= b_len_reg - size_reg;
                            end
                            else if ((left & amask_reg) == '0)
                            begin
                                chunk_reg <= b_base_reg + b_pad_reg + left;
                                wa_en_reg <= 1'b1;
                                wa_len_reg <= b_len_reg - size_reg;
                            end
                            else if (!free_ok)
                                st_reg <= ST_FULL;
                            else
                            begin
                                chunk_reg <= b_base_reg + b_pad_reg;
                                wa_en_reg <= 1'b1;
                                wa_len_reg <= b_pad_reg;
                                wb_two_reg <= 1'b1;
                                w2_idx_reg <= free_idx;
                                w2_base_reg <= b_base_reg + b_pad_reg + size_reg;
                                w2_len_reg <= left;
                                valid_reg[free_idx] <= 1'b1;
                                used_reg <= used_reg + 1'b1;
                            end
                        end
                        else if (size_reg != '0)
                        begin
                            if (b_ok_reg && n_ok_reg)
                            begin
                                wa_en_reg <= 1'b1;
                                wa_len_reg <= b_len_reg + size_reg + n_len_reg;
                                wb_two_reg <= 1'b1;
                                w2_idx_reg <= n_idx_reg;
                                w2_base_reg <= '0;
                                w2_len_reg <= '0;
                                valid_reg[n_idx_reg] <= 1'b0;
                                used_reg <= used_reg - 1'b1;
                            end
                            else if (b_ok_reg)
                            begin
                                wa_en_reg <= 1'b1;
                                wa_len_reg <= b_len_reg + size_reg;
                            end
                            else if (n_ok_reg)
                            begin
                                wa_en_reg <= 1'b1;
                                wa_idx_reg <= n_idx_reg;
                                wa_base_reg <= fst_reg;
                                wa_len_reg <= n_len_reg + size_reg;
                            end
                            else if (!free_ok)
                                st_reg <= ST_FULL;
                            else
                            begin
                                wa_en_reg <= 1'b1;
                                wa_idx_reg <= free_idx;
                                wa_base_reg <= fst_reg;
                                wa_len_reg <= size_reg;
                                valid_reg[free_idx] <= 1'b1;
                                used_reg <= used_reg + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ verif/bfha_checker.sv @@
// checker for the best-fit hole allocator: hole table prediction and response comparison
`timescale 1ns / 100ps
module bfha_checker
    import bfha_pkg::*;
#(
    parameter int MAX_HOLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    bfha_req_if         req,
    bfha_rsp_if         rsp,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        status_t     status;
        logic [31:0] chunk_start;
        logic [6:0]  holes_in_use;
    } answer_t;

    logic [31:0] region_start;
    logic [31:0] region_size;
    logic [31:0] hole_start [MAX_HOLES];
    logic [31:0] hole_size [MAX_HOLES];
    logic        hole_live [MAX_HOLES];
    int          live_holes;
    answer_t     expected_answers [$];

    function automatic void clear_table(logic [31:0] b, logic [31:0] l);
        for (int i = 0; i < MAX_HOLES; i++)
        begin
            hole_start[i] = '0;
            hole_size[i]  = '0;
            hole_live[i]  = 1'b0;
        end
        hole_start[0] = b;
        hole_size[0]  = l;
        hole_live[0]  = 1'b1;
        live_holes    = 1;
    endfunction

    function automatic int first_unused();
        for (int i = 0; i < MAX_HOLES; i++)
            if (!hole_live[i])
                return i;
        return -1;
    endfunction

    function automatic status_t carve_chunk(logic [31:0] size, logic [4:0] lg,
                                            output logic [31:0] chunk);
        logic [31:0] amask;
        logic [31:0] pad;
        logic [31:0] best_pad;
        logic [31:0] left;
        int          best;
        int          slot;
        amask    = (32'd1 << lg) - 32'd1;
        best     = -1;
        best_pad = '0;
        chunk    = '0;
        if (size == 0)
            return ST_NOFIT;
        for (int i = 0; i < MAX_HOLES; i++)
        begin
            if (!hole_live[i])
                continue;
            pad = (32'd0 - hole_start[i]) & amask;
            if (pad >= hole_size[i] || hole_size[i] - pad < size)
                continue;
            if (best < 0 || hole_size[i] < hole_size[best] ||
                (hole_size[i] == hole_size[best] && hole_start[i] < hole_start[best]))
            begin
                best     = i;
                best_pad = pad;
            end
        end
        if (best < 0)
            return ST_NOFIT;
        if (size == hole_size[best])
        begin
            chunk             = hole_start[best];
            hole_live[best]   = 1'b0;
            hole_start[best]  = '0;
            hole_size[best]   = '0;
            live_holes--;
        end
        else if (best_pad == 0)
        begin
            chunk            = hole_start[best];
            hole_start[best] = hole_start[best] + size;
            hole_size[best]  = hole_size[best] - size;
        end
        else
        begin
            left = hole_size[best] - best_pad - size;
            if ((left & amask) == 0)
            begin
                chunk           = hole_start[best] + best_pad + left;
                hole_size[best] = hole_size[best] - size;
            end
            else
            begin
                slot = first_unused();
                if (slot < 0)
                    return ST_FULL;
                hole_start[slot] = hole_start[best] + best_pad + size;
                hole_size[slot]  = left;
                hole_live[slot]  = 1'b1;
                live_holes++;
                chunk           = hole_start[best] + best_pad;
                hole_size[best] = best_pad;
            end
        end
        return ST_OK;
    endfunction

    function automatic status_t return_chunk(logic [31:0] start, logic [31:0] size);
        logic [31:0] stop;
        int          prev;
        int          next;
        int          slot;
        stop = start + size;
        prev = -1;
        next = -1;
        if (size == 0)
            return ST_OK;
        for (int i = 0; i < MAX_HOLES; i++)
            if (hole_live[i] && prev < 0 && hole_start[i] + hole_size[i] == start)
                prev = i;
        for (int i = 0; i < MAX_HOLES; i++)
            if (hole_live[i] && i != prev && next < 0 && hole_start[i] == stop)
                next = i;
        if (prev >= 0 && next >= 0)
        begin
            hole_size[prev]  = hole_size[prev] + size + hole_size[next];
            hole_live[next]  = 1'b0;
            hole_start[next] = '0;
            hole_size[next]  = '0;
            live_holes--;
        end
        else if (prev >= 0)
            hole_size[prev] = hole_size[prev] + size;
        else if (next >= 0)
        begin
            hole_start[next] = start;
            hole_size[next]  = hole_size[next] + size;
        end
        else
        begin
            slot = first_unused();
            if (slot < 0)
                return ST_FULL;
            hole_start[slot] = start;
            hole_size[slot]  = size;
            hole_live[slot]  = 1'b1;
            live_holes++;
        end
        return ST_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t     want;
        logic [31:0] chunk;
        if (!rst_n)
        begin
            region_start = '0;
            region_size  = '0;
            clear_table('0, '0);
            expected_answers.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE)
                    region_start = cfg_wdata;
                else
                    region_size = cfg_wdata;
                clear_table(region_start, region_size);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%t: unexpected response status=%0d chunk=%h holes=%0d", $time,
                             rsp.status, rsp.chunk_start, rsp.holes_in_use);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%t: status expected %0d actual %0d", $time,
                                 want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.chunk_start !== want.chunk_start)
                    begin
                        $display("%t: chunk_start expected %h actual %h", $time,
                                 want.chunk_start, rsp.chunk_start);
                        errors++;
                    end
                    if (rsp.holes_in_use !== want.holes_in_use)
                    begin
                        $display("%t: holes_in_use expected %0d actual %0d", $time,
                                 want.holes_in_use, rsp.holes_in_use);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                chunk = '0;
                if (req.op == OP_ALLOC)
                    want.status = carve_chunk(req.request_size, req.align_log2, chunk);
                else
                    want.status = return_chunk(req.free_start, req.request_size);
                want.chunk_start  = (want.status == ST_OK) ? chunk : '0;
                want.holes_in_use = 7'(live_holes);
                expected_answers.push_back(want);
            end
            pending = expected_answers.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the best-fit hole allocator: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_top;
    import bfha_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct {
        logic [31:0] start;
        logic [31:0] size;
    } chunk_t;

    typedef struct {
        op_t         op;
        logic [31:0] size;
    } sent_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    int          n_alloc;
    int          n_free;
    int          n_phase;
    logic [15:0] stall_pattern;
    int          pattern_pos;
    chunk_t      owned_chunks [$];
    sent_t       in_flight [$];

    bfha_req_if req ();
    bfha_rsp_if rsp ();

    best_fit_hole_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    bfha_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // receiver stall pattern, redrawn as all-ready, alternating or random
    always @(posedge clk)
    begin
        pattern_pos <= pattern_pos + 1;
        if (pattern_pos % 256 == 0)
            case ($urandom_range(0, 3))
                0:       stall_pattern <= 16'hffff;
                1:       stall_pattern <= 16'h5555;
                default: stall_pattern <= 16'($urandom);
            endcase
        rsp.ready <= stall_pattern[pattern_pos % 16];
    end

    // ownership of allocated chunks for well-formed frees
    always @(posedge clk)
    begin
        sent_t s;
        chunk_t c;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready && in_flight.size() != 0)
            begin
                s = in_flight.pop_front();
                if (s.op == OP_ALLOC && rsp.status == ST_OK)
                begin
                    c.start = rsp.chunk_start;
                    c.size  = s.size;
                    owned_chunks.push_back(c);
                end
            end
            if (req.valid && req.ready)
            begin
                s.op   = op_t'(req.op);
                s.size = req.request_size;
                in_flight.push_back(s);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d responses outstanding", pending);
            $display("** best_fit_hole_allocator: FAILED **");
            $finish;
        end
    end

    task automatic send(op_t op, logic [31:0] size, logic [4:0] lg, logic [31:0] start);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid        <= 1'b1;
        req.op           <= op;
        req.request_size <= size;
        req.align_log2   <= lg;
        req.free_start   <= start;
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_free++;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || in_flight.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_region(logic [31:0] b, logic [31:0] l);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_index <= CFG_LENGTH;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_we <= 1'b0;
        owned_chunks.delete();
        n_phase++;
    endtask

    task automatic random_traffic(int count);
        int     k;
        chunk_t c;
        logic [31:0] size;
        logic [4:0]  lg;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40 && owned_chunks.size() != 0)
            begin
                k = $urandom_range(0, owned_chunks.size() - 1);
                c = owned_chunks[k];
                owned_chunks.delete(k);
                send(OP_FREE, c.size, 5'($urandom), c.start);
            end
            else if (k < 48)
                send(OP_FREE, ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                     32'($urandom_range(0, 64)), 5'($urandom), 32'($urandom));
            else
            begin
                k    = $urandom_range(0, 19);
                size = (k == 0) ? 32'($urandom) : (k == 1) ? 32'd0 :
                       32'($urandom_range(1, 96));
                lg   = ($urandom_range(0, 9) == 0) ? 5'($urandom) :
                       5'($urandom_range(0, 6));
                send(OP_ALLOC, size, lg, 32'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BASE;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.op        = OP_ALLOC;
        req.request_size = '0;
        req.align_log2   = '0;
        req.free_start   = '0;
        rsp.ready     = 1'b0;
        stall_pattern = 16'hffff;
        pattern_pos   = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        n_alloc       = 0;
        n_free        = 0;
        n_phase       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty region straight out of reset
        send(OP_ALLOC, 32'd1, 5'd0, 32'd0);
        send(OP_ALLOC, 32'd0, 5'd0, 32'd0);
        send(OP_FREE, 32'd0, 5'd0, 32'hffff_ffff);
        send(OP_ALLOC, 32'hffff_ffff, 5'd31, 32'h0);
        send(OP_FREE, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
        send(OP_ALLOC, 32'h8000_0000, 5'd31, 32'd0);

        // whole hole, front and middle cuts, then merging frees
        set_region(32'h0000_0100, 32'h0000_1000);
        send(OP_ALLOC, 32'h1000, 5'd0, 32'd0);
        send(OP_ALLOC, 32'h1, 5'd0, 32'd0);
        send(OP_FREE, 32'h1000, 5'd0, 32'h100);
        send(OP_ALLOC, 32'h10, 5'd8, 32'd0);
        send(OP_ALLOC, 32'h10, 5'd4, 32'd0);
        send(OP_ALLOC, 32'h8, 5'd9, 32'd0);
        send(OP_ALLOC, 32'h20, 5'd3, 32'd0);
        send(OP_ALLOC, 32'h10, 5'd31, 32'd0);
        send(OP_FREE, 32'h10, 5'd0, 32'h110);
        send(OP_FREE, 32'h10, 5'd0, 32'h100);
        send(OP_FREE, 32'h8, 5'd0, 32'h200);
        send(OP_ALLOC, 32'h2000, 5'd0, 32'd0);

        // wrapping region at the top of the address space
        set_region(32'hffff_ff00, 32'h0000_0200);
        send(OP_ALLOC, 32'h100, 5'd0, 32'd0);
        send(OP_ALLOC, 32'h80, 5'd7, 32'd0);
        send(OP_FREE, 32'h100, 5'd0, 32'hffff_ff00);

        // fill the table with middle cuts, then free against a full table
        set_region(32'h0, 32'h0001_0000);
        for (int i = 0; i < 72; i++)
            send(OP_ALLOC, 32'd1, 5'd4, 32'd0);
        random_traffic(40);

        set_region(32'h0, 32'hffff_ffff);
        random_traffic(100);
        set_region(32'hffff_ffff, 32'h0);
        random_traffic(20);
        set_region(32'($urandom), 32'($urandom));
        random_traffic(100);
        set_region(32'h0000_1000, 32'h0000_0800);
        random_traffic(150);
        set_region(32'($urandom_range(0, 32'hffff)), 32'($urandom_range(1, 4096)));
        random_traffic(120);
        drain();

        $display("covered %0d allocates and %0d frees over %0d region settings",
                 n_alloc, n_free, n_phase + 1);
        $display("including table fill, wrapping regions and frees of owned chunks");
        if (errors == 0)
            $display("** best_fit_hole_allocator: PASSED **");
        else
            $display("** best_fit_hole_allocator: FAILED **");
        $finish;
    end

endmodule

@@ best_fit_hole_allocator.f @@
rtl/bfha_pkg.sv
rtl/bfha_if.sv
rtl/bfha_ram.sv
rtl/best_fit_hole_allocator.sv
verif/bfha_checker.sv
verif/tb_top.sv
